FILE: rtl/core/ordered_hash_set_engine_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ordered hash set engine
// Clocked implication checks, disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ORDERED_HASH_SET_ENGINE_UNIT_MACROS_SVH
`define ORDERED_HASH_SET_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication
`define OHS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define OHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ohs_pkg.sv
// ----------------------------------------------------------------------------
// ohs_pkg
// Operation and status codes, key layout, controller states and the
// memory write-enable bundle of the ordered hash set engine.
// ----------------------------------------------------------------------------
package ohs_pkg;

    localparam int KEY_W = 99;

    localparam logic [2:0] KIND_ADD      = 3'd0;
    localparam logic [2:0] KIND_REMOVE   = 3'd1;
    localparam logic [2:0] KIND_CONTAINS = 3'd2;
    localparam logic [2:0] KIND_READ     = 3'd3;
    localparam logic [2:0] KIND_CLEAR    = 3'd4;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_HASH,
        ST_BKT,
        ST_HEAD,
        ST_CMP,
        ST_DECIDE,
        ST_POP,
        ST_ALLOC,
        ST_SHR,
        ST_SHW,
        ST_FREE,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic key;
        logic link;
        logic pos;
        logic ord;
        logic bkt;
    } t_mem_we;

endpackage

FILE: rtl/core/ohs_hash.sv
// ----------------------------------------------------------------------------
// ohs_hash
// Registered bucket index: xor-rotate fold of the key, then scaled into
// the bucket range by one small multiply.
// ----------------------------------------------------------------------------
module ohs_hash #(
    parameter int BUCKETS = 256,
    parameter int BW      = 8
) (
    input  logic          i_clk,
    input  logic [2:0]    i_type,
    input  logic [31:0]   i_a,
    input  logic [31:0]   i_b,
    input  logic [31:0]   i_c,
    output logic [BW-1:0] o_bucket
);

    logic [31:0] h32;
    logic [15:0] h16;
    logic [32:0] prod;
    logic [BW-1:0] r_bucket;

    // Fold the key to 16 bits and scale into the bucket range
    always_comb begin
        h32  = i_a ^ {i_b[20:0], i_b[31:21]} ^ {i_c[9:0], i_c[31:10]} ^ {29'd0, i_type};
        h16  = h32[31:16] ^ h32[15:0];
        prod = 33'(h16) * 33'(BUCKETS);
    end

    always_ff @(posedge i_clk) begin
        r_bucket <= BW'(prod >> 16);
    end

    assign o_bucket = r_bucket;

endmodule

FILE: rtl/core/ohs_store.sv
// ----------------------------------------------------------------------------
// ohs_store
// Synchronous memories of the set: keys, chain links, slot positions,
// insertion order and bucket heads; one write and one read port each.
// ----------------------------------------------------------------------------
module ohs_store #(
    parameter int CAPACITY = 256,
    parameter int BUCKETS  = 256,
    parameter int AW       = 8,
    parameter int SW       = 9,
    parameter int BW       = 8
) (
    input  logic                    i_clk,
    input  ohs_pkg::t_mem_we        i_we,
    input  logic [AW-1:0]           i_key_wa,
    input  logic [AW-1:0]           i_key_ra,
    input  logic [ohs_pkg::KEY_W-1:0] i_key_wd,
    output logic [ohs_pkg::KEY_W-1:0] o_key_rd,
    input  logic [AW-1:0]           i_link_wa,
    input  logic [AW-1:0]           i_link_ra,
    input  logic [SW-1:0]           i_link_wd,
    output logic [SW-1:0]           o_link_rd,
    input  logic [AW-1:0]           i_pos_wa,
    input  logic [AW-1:0]           i_pos_ra,
    input  logic [AW-1:0]           i_pos_wd,
    output logic [AW-1:0]           o_pos_rd,
    input  logic [AW-1:0]           i_ord_wa,
    input  logic [AW-1:0]           i_ord_ra,
    input  logic [AW-1:0]           i_ord_wd,
    output logic [AW-1:0]           o_ord_rd,
    input  logic [BW-1:0]           i_bkt_wa,
    input  logic [BW-1:0]           i_bkt_ra,
    input  logic [SW-1:0]           i_bkt_wd,
    output logic [SW-1:0]           o_bkt_rd
);

    logic [ohs_pkg::KEY_W-1:0] key_mem  [CAPACITY];
    logic [SW-1:0]             link_mem [CAPACITY];
    logic [AW-1:0]             pos_mem  [CAPACITY];
    logic [AW-1:0]             ord_mem  [CAPACITY];
    logic [SW-1:0]             bkt_mem  [BUCKETS];

    // Write and registered read of every memory
    always_ff @(posedge i_clk) begin
        if (i_we.key) begin
            key_mem[i_key_wa] <= i_key_wd;
        end
        if (i_we.link) begin
            link_mem[i_link_wa] <= i_link_wd;
        end
        if (i_we.pos) begin
            pos_mem[i_pos_wa] <= i_pos_wd;
        end
        if (i_we.ord) begin
            ord_mem[i_ord_wa] <= i_ord_wd;
        end
        if (i_we.bkt) begin
            bkt_mem[i_bkt_wa] <= i_bkt_wd;
        end
        o_key_rd  <= key_mem[i_key_ra];
        o_link_rd <= link_mem[i_link_ra];
        o_pos_rd  <= pos_mem[i_pos_ra];
        o_ord_rd  <= ord_mem[i_ord_ra];
        o_bkt_rd  <= bkt_mem[i_bkt_ra];
    end

endmodule

FILE: rtl/core/ohs_ctrl.sv
// ----------------------------------------------------------------------------
// ohs_ctrl
// Sequencer: bucket sweep, chain walk, allocation, unlink with order-list
// shift, read at position, and the output register.
// ----------------------------------------------------------------------------
`include "ordered_hash_set_engine_unit_macros.svh"

module ohs_ctrl #(
    parameter int CAPACITY = 256,
    parameter int BUCKETS  = 256,
    parameter int AW       = 8,
    parameter int SW       = 9,
    parameter int BW       = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [2:0]                i_kind,
    input  logic [2:0]                i_key_type,
    input  logic [31:0]               i_key_word_a,
    input  logic [31:0]               i_key_word_b,
    input  logic [31:0]               i_key_word_c,
    input  logic [7:0]                i_position,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_success,
    output logic [1:0]                o_status,
    output logic [2:0]                o_found_type,
    output logic [31:0]               o_found_word_a,
    output logic [31:0]               o_found_word_b,
    output logic [31:0]               o_found_word_c,
    output logic [8:0]                o_entry_total,
    output ohs_pkg::t_mem_we          o_we,
    output logic [AW-1:0]             o_key_wa,
    output logic [AW-1:0]             o_key_ra,
    output logic [ohs_pkg::KEY_W-1:0] o_key_wd,
    input  logic [ohs_pkg::KEY_W-1:0] i_key_rd,
    output logic [AW-1:0]             o_link_wa,
    output logic [AW-1:0]             o_link_ra,
    output logic [SW-1:0]             o_link_wd,
    input  logic [SW-1:0]             i_link_rd,
    output logic [AW-1:0]             o_pos_wa,
    output logic [AW-1:0]             o_pos_ra,
    output logic [AW-1:0]             o_pos_wd,
    input  logic [AW-1:0]             i_pos_rd,
    output logic [AW-1:0]             o_ord_wa,
    output logic [AW-1:0]             o_ord_ra,
    output logic [AW-1:0]             o_ord_wd,
    input  logic [AW-1:0]             i_ord_rd,
    output logic [BW-1:0]             o_bkt_wa,
    output logic [BW-1:0]             o_bkt_ra,
    output logic [SW-1:0]             o_bkt_wd,
    input  logic [SW-1:0]             i_bkt_rd
);

    localparam logic [SW-1:0] NIL      = SW'(CAPACITY);
    localparam logic [BW-1:0] LAST_BKT = BW'(BUCKETS - 1);

    ohs_pkg::t_state r_state, n_state;

    logic [2:0]  r_kind, n_kind;
    logic [2:0]  r_type, n_type;
    logic [31:0] r_a, n_a, r_b, n_b, r_c, n_c;
    logic [7:0]  r_pos, n_pos;
    logic [SW-1:0] r_count, n_count;
    logic [SW-1:0] r_free, n_free;
    logic [SW-1:0] r_fresh, n_fresh;
    logic [SW-1:0] r_head, n_head;
    logic [SW-1:0] r_cur, n_cur;
    logic [SW-1:0] r_prev, n_prev;
    logic [SW-1:0] r_next, n_next;
    logic          r_found, n_found;
    logic [AW-1:0] r_fpos, n_fpos;
    logic [AW-1:0] r_idx, n_idx;
    logic [BW-1:0] r_sweep, n_sweep;
    logic          r_clear, n_clear;
    logic          r_ok, n_ok;
    logic [1:0]    r_st, n_st;
    logic [ohs_pkg::KEY_W-1:0] r_fkey, n_fkey;
    logic          r_ovalid, n_ovalid;
    logic          r_osucc, n_osucc;
    logic [1:0]    r_ostat, n_ostat;
    logic [ohs_pkg::KEY_W-1:0] r_okey, n_okey;
    logic [SW-1:0] r_ocount, n_ocount;

    logic [BW-1:0] bucket;
    logic [ohs_pkg::KEY_W-1:0] key;

    ohs_hash #(
        .BUCKETS (BUCKETS),
        .BW      (BW)
    ) u_hash (
        .i_clk    (i_clk),
        .i_type   (r_type),
        .i_a      (r_a),
        .i_b      (r_b),
        .i_c      (r_c),
        .o_bucket (bucket)
    );

    assign key = {r_type, r_a, r_b, r_c};

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ohs_pkg::ST_INIT;
            r_count  <= '0;
            r_free   <= NIL;
            r_fresh  <= '0;
            r_sweep  <= '0;
            r_clear  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_free   <= n_free;
            r_fresh  <= n_fresh;
            r_sweep  <= n_sweep;
            r_clear  <= n_clear;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_type   <= n_type;
        r_a      <= n_a;
        r_b      <= n_b;
        r_c      <= n_c;
        r_pos    <= n_pos;
        r_head   <= n_head;
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_next   <= n_next;
        r_found  <= n_found;
        r_fpos   <= n_fpos;
        r_idx    <= n_idx;
        r_ok     <= n_ok;
        r_st     <= n_st;
        r_fkey   <= n_fkey;
        r_osucc  <= n_osucc;
        r_ostat  <= n_ostat;
        r_okey   <= n_okey;
        r_ocount <= n_ocount;
    end

    // Next state, memory commands and results
    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_type   = r_type;
        n_a      = r_a;
        n_b      = r_b;
        n_c      = r_c;
        n_pos    = r_pos;
        n_count  = r_count;
        n_free   = r_free;
        n_fresh  = r_fresh;
        n_head   = r_head;
        n_cur    = r_cur;
        n_prev   = r_prev;
        n_next   = r_next;
        n_found  = r_found;
        n_fpos   = r_fpos;
        n_idx    = r_idx;
        n_sweep  = r_sweep;
        n_clear  = r_clear;
        n_ok     = r_ok;
        n_st     = r_st;
        n_fkey   = r_fkey;
        n_ovalid = r_ovalid && !i_ready;
        n_osucc  = r_osucc;
        n_ostat  = r_ostat;
        n_okey   = r_okey;
        n_ocount = r_ocount;
        o_ready  = 1'b0;
        o_we     = '0;
        o_key_wa = AW'(r_cur);
        o_key_ra = '0;
        o_key_wd = key;
        o_link_wa = '0;
        o_link_ra = '0;
        o_link_wd = r_next;
        o_pos_wa = AW'(r_cur);
        o_pos_ra = '0;
        o_pos_wd = AW'(r_count);
        o_ord_wa = AW'(r_count);
        o_ord_ra = '0;
        o_ord_wd = AW'(r_cur);
        o_bkt_wa = bucket;
        o_bkt_ra = bucket;
        o_bkt_wd = NIL;

        unique case (r_state)
            // Sweep bucket heads to null
            ohs_pkg::ST_INIT: begin
                o_we.bkt = 1'b1;
                o_bkt_wa = r_sweep;
                o_bkt_wd = NIL;
                if (r_sweep == LAST_BKT) begin
                    n_state = r_clear ? ohs_pkg::ST_EMIT : ohs_pkg::ST_IDLE;
                    n_clear = 1'b0;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            // Take a new transfer
            ohs_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_kind = i_kind;
                    n_type = i_key_type;
                    n_a    = i_key_word_a;
                    n_b    = i_key_word_b;
                    n_c    = i_key_word_c;
                    n_pos  = i_position;
                    n_ok   = 1'b0;
                    n_st   = ohs_pkg::STATUS_OK;
                    n_fkey = '0;
                    if ((i_kind == ohs_pkg::KIND_ADD || i_kind == ohs_pkg::KIND_REMOVE ||
                         i_kind == ohs_pkg::KIND_CONTAINS) && i_key_type != 3'd0) begin
                        n_state = ohs_pkg::ST_HASH;
                    end else if (i_kind == ohs_pkg::KIND_READ) begin
                        if (32'(i_position) < 32'(r_count)) begin
                            n_state = ohs_pkg::ST_RD1;
                        end else begin
                            n_st    = ohs_pkg::STATUS_RANGE;
                            n_state = ohs_pkg::ST_EMIT;
                        end
                    end else if (i_kind == ohs_pkg::KIND_CLEAR) begin
                        n_count = '0;
                        n_free  = NIL;
                        n_fresh = '0;
                        n_sweep = '0;
                        n_clear = 1'b1;
                        n_state = ohs_pkg::ST_INIT;
                    end else begin
                        n_state = ohs_pkg::ST_EMIT;
                    end
                end
            end
            ohs_pkg::ST_HASH: begin
                n_state = ohs_pkg::ST_BKT;
            end
            // Read the bucket head
            ohs_pkg::ST_BKT: begin
                o_bkt_ra = bucket;
                n_state  = ohs_pkg::ST_HEAD;
            end
            ohs_pkg::ST_HEAD: begin
                n_head = i_bkt_rd;
                n_prev = NIL;
                if (i_bkt_rd == NIL) begin
                    n_found = 1'b0;
                    n_state = ohs_pkg::ST_DECIDE;
                end else begin
                    o_key_ra  = AW'(i_bkt_rd);
                    o_link_ra = AW'(i_bkt_rd);
                    o_pos_ra  = AW'(i_bkt_rd);
                    n_cur     = i_bkt_rd;
                    n_state   = ohs_pkg::ST_CMP;
                end
            end
            // Compare one chain slot, advance on mismatch
            ohs_pkg::ST_CMP: begin
                if (i_key_rd == key) begin
                    n_found = 1'b1;
                    n_next  = i_link_rd;
                    n_fpos  = i_pos_rd;
                    n_state = ohs_pkg::ST_DECIDE;
                end else begin
                    n_prev = r_cur;
                    n_cur  = i_link_rd;
                    if (i_link_rd == NIL) begin
                        n_found = 1'b0;
                        n_state = ohs_pkg::ST_DECIDE;
                    end else begin
                        o_key_ra  = AW'(i_link_rd);
                        o_link_ra = AW'(i_link_rd);
                        o_pos_ra  = AW'(i_link_rd);
                    end
                end
            end
            ohs_pkg::ST_DECIDE: begin
                n_state = ohs_pkg::ST_EMIT;
                priority case (r_kind)
                    ohs_pkg::KIND_ADD: begin
                        if (r_found) begin
                            n_state = ohs_pkg::ST_EMIT;
                        end else if (r_count >= SW'(CAPACITY)) begin
                            n_st = ohs_pkg::STATUS_FULL;
                        end else if (r_free != NIL) begin
                            o_link_ra = AW'(r_free);
                            n_cur     = r_free;
                            n_state   = ohs_pkg::ST_POP;
                        end else begin
                            n_cur   = r_fresh;
                            n_fresh = r_fresh + 1'b1;
                            n_state = ohs_pkg::ST_ALLOC;
                        end
                    end
                    ohs_pkg::KIND_REMOVE: begin
                        if (r_found) begin
                            if (r_prev == NIL) begin
                                o_we.bkt = 1'b1;
                                o_bkt_wd = r_next;
                            end else begin
                                o_we.link = 1'b1;
                                o_link_wa = AW'(r_prev);
                                o_link_wd = r_next;
                            end
                            n_idx   = r_fpos;
                            n_state = ohs_pkg::ST_SHR;
                        end
                    end
                    ohs_pkg::KIND_CONTAINS: begin
                        n_ok = r_found;
                    end
                    default: begin
                        n_state = ohs_pkg::ST_EMIT;
                    end
                endcase
            end
            // Pop the free list
            ohs_pkg::ST_POP: begin
                n_free  = i_link_rd;
                n_state = ohs_pkg::ST_ALLOC;
            end
            // Write the new slot, its order entry and position, and push it on its bucket
            ohs_pkg::ST_ALLOC: begin
                o_we.key  = 1'b1;
                o_we.link = 1'b1;
                o_we.bkt  = 1'b1;
                o_we.ord  = 1'b1;
                o_we.pos  = 1'b1;
                o_link_wa = AW'(r_cur);
                o_link_wd = r_head;
                o_bkt_wd  = r_cur;
                n_count   = r_count + 1'b1;
                n_ok      = 1'b1;
                n_state   = ohs_pkg::ST_EMIT;
            end
            // Shift the order list down by one
            ohs_pkg::ST_SHR: begin
                if (SW'(r_idx) + 1'b1 < r_count) begin
                    o_ord_ra = AW'(SW'(r_idx) + 1'b1);
                    n_state  = ohs_pkg::ST_SHW;
                end else begin
                    n_state = ohs_pkg::ST_FREE;
                end
            end
            ohs_pkg::ST_SHW: begin
                o_we.ord = 1'b1;
                o_we.pos = 1'b1;
                o_ord_wa = r_idx;
                o_ord_wd = i_ord_rd;
                o_pos_wa = i_ord_rd;
                o_pos_wd = r_idx;
                n_idx    = AW'(SW'(r_idx) + 1'b1);
                n_state  = ohs_pkg::ST_SHR;
            end
            // Return the slot to the free list
            ohs_pkg::ST_FREE: begin
                o_we.link = 1'b1;
                o_link_wa = AW'(r_cur);
                o_link_wd = r_free;
                n_free    = r_cur;
                n_count   = r_count - 1'b1;
                n_ok      = 1'b1;
                n_state   = ohs_pkg::ST_EMIT;
            end
            // Read at position: order list, then key
            ohs_pkg::ST_RD1: begin
                o_ord_ra = AW'(r_pos);
                n_state  = ohs_pkg::ST_RD2;
            end
            ohs_pkg::ST_RD2: begin
                o_key_ra = i_ord_rd;
                n_state  = ohs_pkg::ST_RD3;
            end
            ohs_pkg::ST_RD3: begin
                n_fkey  = i_key_rd;
                n_ok    = 1'b1;
                n_state = ohs_pkg::ST_EMIT;
            end
            // Load the output register once it is free
            ohs_pkg::ST_EMIT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_osucc  = r_ok;
                    n_ostat  = r_st;
                    n_okey   = r_fkey;
                    n_ocount = r_count;
                    n_state  = ohs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ohs_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_valid        = r_ovalid;
    assign o_success      = r_osucc;
    assign o_status       = r_ostat;
    assign o_found_type   = r_okey[98:96];
    assign o_found_word_a = r_okey[95:64];
    assign o_found_word_b = r_okey[63:32];
    assign o_found_word_c = r_okey[31:0];
    assign o_entry_total  = 9'(r_ocount);

    `OHS_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= SW'(CAPACITY), "count above capacity")
    `OHS_ASSERT_IMPL(a_free_range, i_clk, i_rst_n, r_free != NIL, r_free < SW'(CAPACITY), "free head out of range")
    `OHS_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_valid && o_ready, r_state != ohs_pkg::ST_IDLE, "took transfer but stayed idle")

endmodule

FILE: rtl/core/ordered_hash_set_engine_unit.sv
// Output stalls may hold any result. Unused kinds, key type zero and reads beyond the count
// go straight to the result; other reads fetch the order entry, then the key; clear sweeps
// all bucket heads. Add, remove and contains hash, read the bucket head and walk the chain;
// a new add reuses a freed slot first; a hit remove unlinks and shifts later positions down.
// Throughput: one operation at a time; next transfer taken the cycle after the result loads.
// Reset: synchronous, active low; bucket heads are swept to null before the first transfer.
// ----------------------------------------------------------------------------
// ordered_hash_set_engine_unit
// Fixed-capacity typed key set with hashed chains, free list and insertion order.
// ----------------------------------------------------------------------------
module ordered_hash_set_engine_unit #(
    parameter int CAPACITY = 256,
    parameter int BUCKETS  = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_kind,
    input  logic [2:0]  i_key_type,
    input  logic [31:0] i_key_word_a,
    input  logic [31:0] i_key_word_b,
    input  logic [31:0] i_key_word_c,
    input  logic [7:0]  i_position,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_success,
    output logic [1:0]  o_status,
    output logic [2:0]  o_found_type,
    output logic [31:0] o_found_word_a,
    output logic [31:0] o_found_word_b,
    output logic [31:0] o_found_word_c,
    output logic [8:0]  o_entry_total
);

    localparam int AW = $clog2(CAPACITY);
    localparam int SW = $clog2(CAPACITY + 1);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

    ohs_pkg::t_mem_we          we;
    logic [AW-1:0]             key_wa, key_ra, link_wa, link_ra;
    logic [AW-1:0]             pos_wa, pos_ra, pos_wd, pos_rd;
    logic [AW-1:0]             ord_wa, ord_ra, ord_wd, ord_rd;
    logic [ohs_pkg::KEY_W-1:0] key_wd, key_rd;
    logic [SW-1:0]             link_wd, link_rd, bkt_wd, bkt_rd;
    logic [BW-1:0]             bkt_wa, bkt_ra;

    ohs_ctrl #(
        .CAPACITY (CAPACITY), .BUCKETS (BUCKETS), .AW (AW), .SW (SW), .BW (BW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_key_type     (i_key_type),
        .i_key_word_a   (i_key_word_a),
        .i_key_word_b   (i_key_word_b),
        .i_key_word_c   (i_key_word_c),
        .i_position     (i_position),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_success      (o_success),
        .o_status       (o_status),
        .o_found_type   (o_found_type),
        .o_found_word_a (o_found_word_a),
        .o_found_word_b (o_found_word_b),
        .o_found_word_c (o_found_word_c),
        .o_entry_total  (o_entry_total),
        .o_we           (we),
        .o_key_wa       (key_wa),
        .o_key_ra       (key_ra),
        .o_key_wd       (key_wd),
        .i_key_rd       (key_rd),
        .o_link_wa      (link_wa),
        .o_link_ra      (link_ra),
        .o_link_wd      (link_wd),
        .i_link_rd      (link_rd),
        .o_pos_wa       (pos_wa),
        .o_pos_ra       (pos_ra),
        .o_pos_wd       (pos_wd),
        .i_pos_rd       (pos_rd),
        .o_ord_wa       (ord_wa),
        .o_ord_ra       (ord_ra),
        .o_ord_wd       (ord_wd),
        .i_ord_rd       (ord_rd),
        .o_bkt_wa       (bkt_wa),
        .o_bkt_ra       (bkt_ra),
        .o_bkt_wd       (bkt_wd),
        .i_bkt_rd       (bkt_rd)
    );

    ohs_store #(
        .CAPACITY (CAPACITY), .BUCKETS (BUCKETS), .AW (AW), .SW (SW), .BW (BW)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_key_wa  (key_wa),
        .i_key_ra  (key_ra),
        .i_key_wd  (key_wd),
        .o_key_rd  (key_rd),
        .i_link_wa (link_wa),
        .i_link_ra (link_ra),
        .i_link_wd (link_wd),
        .o_link_rd (link_rd),
        .i_pos_wa  (pos_wa),
        .i_pos_ra  (pos_ra),
        .i_pos_wd  (pos_wd),
        .o_pos_rd  (pos_rd),
        .i_ord_wa  (ord_wa),
        .i_ord_ra  (ord_ra),
        .i_ord_wd  (ord_wd),
        .o_ord_rd  (ord_rd),
        .i_bkt_wa  (bkt_wa),
        .i_bkt_ra  (bkt_ra),
        .i_bkt_wd  (bkt_wd),
        .o_bkt_rd  (bkt_rd)
    );

endmodule

FILE: test/ordered_hash_set_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// ordered_hash_set_engine_unit_tb
// Drives add, remove, contains, read-at-position and clear operations through
// the valid/ready channels and checks every result against a software model
// of the set that keeps its keys in insertion order.
// ----------------------------------------------------------------------------
module ordered_hash_set_engine_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          SET_DEPTH   = 256;
    localparam logic [2:0]  KIND_SPARE5 = 3'd5;
    localparam logic [2:0]  KIND_SPARE6 = 3'd6;
    localparam logic [2:0]  KIND_SPARE7 = 3'd7;

    typedef struct packed {
        logic [2:0]  t;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } t_set_key;

    typedef struct packed {
        logic        success;
        logic [1:0]  status;
        logic [2:0]  ft;
        logic [31:0] fa;
        logic [31:0] fb;
        logic [31:0] fc;
        logic [8:0]  total;
    } t_set_result;

    // Model of the set contents plus the queue of results still owed
    class set_scoreboard;
        t_set_key    held_keys[$];
        t_set_result owed_results[$];
        int          errors;
        int          checked;
        int          per_kind[8];

        function int find_key(t_set_key k);
            foreach (held_keys[i]) begin
                if (held_keys[i] == k) return i;
            end
            return -1;
        endfunction

        // Apply one accepted operation and queue its expected result
        function void note_input(logic [2:0] kind, t_set_key k, logic [7:0] pos);
            t_set_result r;
            int          idx;
            r = '0;
            per_kind[kind]++;
            if (kind <= ohs_pkg::KIND_CONTAINS && k.t != 3'd0) begin
                idx = find_key(k);
                case (kind)
                    ohs_pkg::KIND_ADD: begin
                        if (idx < 0) begin
                            if (held_keys.size() >= SET_DEPTH) begin
                                r.status = ohs_pkg::STATUS_FULL;
                            end else begin
                                held_keys.push_back(k);
                                r.success = 1'b1;
                            end
                        end
                    end
                    ohs_pkg::KIND_REMOVE: begin
                        if (idx >= 0) begin
                            held_keys.delete(idx);
                            r.success = 1'b1;
                        end
                    end
                    default: r.success = (idx >= 0);
                endcase
            end else if (kind == ohs_pkg::KIND_READ) begin
                if (pos < held_keys.size()) begin
                    r.success = 1'b1;
                    r.ft      = held_keys[pos].t;
                    r.fa      = held_keys[pos].a;
                    r.fb      = held_keys[pos].b;
                    r.fc      = held_keys[pos].c;
                end else begin
                    r.status = ohs_pkg::STATUS_RANGE;
                end
            end else if (kind == ohs_pkg::KIND_CLEAR) begin
                held_keys.delete();
            end
            r.total = 9'(held_keys.size());
            owed_results.push_back(r);
        endfunction

        // Compare one result transfer with the oldest owed result
        function void check_result(t_set_result got);
            t_set_result want;
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            checked++;
            if (got.success !== want.success) begin
                $display("%0t: success exp %0d got %0d", $time, want.success, got.success);
                errors++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.ft !== want.ft) begin
                $display("%0t: found_type exp %0d got %0d", $time, want.ft, got.ft);
                errors++;
            end
            if (got.fa !== want.fa) begin
                $display("%0t: found_word_a exp %h got %h", $time, want.fa, got.fa);
                errors++;
            end
            if (got.fb !== want.fb) begin
                $display("%0t: found_word_b exp %h got %h", $time, want.fb, got.fb);
                errors++;
            end
            if (got.fc !== want.fc) begin
                $display("%0t: found_word_c exp %h got %h", $time, want.fc, got.fc);
                errors++;
            end
            if (got.total !== want.total) begin
                $display("%0t: entry_total exp %0d got %0d", $time, want.total, got.total);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_kind;
    logic [2:0]  i_key_type;
    logic [31:0] i_key_word_a;
    logic [31:0] i_key_word_b;
    logic [31:0] i_key_word_c;
    logic [7:0]  i_position;
    logic        o_valid;
    logic        i_ready;
    logic        o_success;
    logic [1:0]  o_status;
    logic [2:0]  o_found_type;
    logic [31:0] o_found_word_a;
    logic [31:0] o_found_word_b;
    logic [31:0] o_found_word_c;
    logic [8:0]  o_entry_total;

    ordered_hash_set_engine_unit u_top (.*);

    set_scoreboard sb;
    t_set_key      key_pool[32];
    int            snd_idle_pct;
    int            rcv_idle_pct;
    int            hold_cycles;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #10ms;
        $display("ordered_hash_set_engine_unit_tb: errors");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off when requested
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles = hold_cycles - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result('{o_success, o_status, o_found_type, o_found_word_a,
                              o_found_word_b, o_found_word_c, o_entry_total});
        end
    end

    // Offer one operation and hold it until the transfer completes
    task automatic send_op(logic [2:0] kind, t_set_key k, logic [7:0] pos);
        while ($urandom_range(99) < snd_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_key_type   <= k.t;
        i_key_word_a <= k.a;
        i_key_word_b <= k.b;
        i_key_word_c <= k.c;
        i_position   <= pos;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(kind, k, pos);
    endtask

    function automatic t_set_key pick_key();
        t_set_key k;
        if ($urandom_range(99) < 75) begin
            k = key_pool[$urandom_range(31)];
        end else begin
            k = {3'($urandom_range(1, 7)), 32'($urandom), 32'($urandom), 32'($urandom)};
        end
        if ($urandom_range(99) < 3) k.t = 3'd0;
        return k;
    endfunction

    function automatic logic [7:0] pick_pos();
        int n;
        n = sb.held_keys.size();
        if (n > 0 && $urandom_range(99) < 80) return 8'($urandom_range(n - 1));
        return 8'($urandom);
    endfunction

    // Weighted random operation over the key pool
    task automatic random_op();
        int       w;
        t_set_key k;
        w = $urandom_range(99);
        k = pick_key();
        if (w < 40)      send_op(ohs_pkg::KIND_ADD, k, 8'($urandom));
        else if (w < 60) send_op(ohs_pkg::KIND_REMOVE, k, 8'($urandom));
        else if (w < 75) send_op(ohs_pkg::KIND_CONTAINS, k, 8'($urandom));
        else if (w < 95) send_op(ohs_pkg::KIND_READ, k, pick_pos());
        else if (w < 97) send_op(ohs_pkg::KIND_CLEAR, k, 8'($urandom));
        else             send_op(3'($urandom_range(5, 7)), k, 8'($urandom));
    endtask

    // Fill to capacity, push past full, then drain part of it from random spots
    task automatic fill_and_drain();
        t_set_key k;
        send_op(ohs_pkg::KIND_CLEAR, pick_key(), 8'd0);
        for (int i = 0; i < SET_DEPTH; i++) begin
            k = {3'($urandom_range(1, 7)), 32'(i), 32'($urandom), 32'(i * 7)};
            send_op(ohs_pkg::KIND_ADD, k, 8'd0);
        end
        send_op(ohs_pkg::KIND_ADD, sb.held_keys[17], 8'd0);
        send_op(ohs_pkg::KIND_ADD, {3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 8'd0);
        send_op(ohs_pkg::KIND_READ, pick_key(), 8'd255);
        send_op(ohs_pkg::KIND_CONTAINS, sb.held_keys[200], 8'd0);
        for (int i = 0; i < 60; i++) begin
            if ($urandom_range(1)) send_op(ohs_pkg::KIND_REMOVE, sb.held_keys[$urandom_range(
                                           sb.held_keys.size() - 1)], 8'd0);
            else send_op(ohs_pkg::KIND_READ, pick_key(), pick_pos());
        end
    endtask

    initial begin
        t_set_key k0;
        t_set_key k1;
        int       wait_cycles;
        sb           = new();
        snd_idle_pct = 10;
        rcv_idle_pct = 81;
        hold_cycles  = 0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_kind       = ohs_pkg::KIND_CONTAINS;
        i_key_type   = 3'd0;
        i_key_word_a = '0;
        i_key_word_b = '0;
        i_key_word_c = '0;
        i_position   = '0;
        for (int i = 0; i < 32; i++) begin
            key_pool[i].t = 3'($urandom_range(1, 7));
            key_pool[i].a = $urandom;
            key_pool[i].b = (i % 2) ? $urandom : 32'd0;
            key_pool[i].c = (i % 2) ? $urandom : 32'd0;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, duplicates, type zero, range, spare kinds, clear
        k0 = {3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        k1 = {3'd1, 32'd0, 32'd0, 32'd0};
        send_op(ohs_pkg::KIND_READ, k1, 8'd0);
        send_op(ohs_pkg::KIND_ADD, k0, 8'd0);
        send_op(ohs_pkg::KIND_ADD, k1, 8'd0);
        send_op(ohs_pkg::KIND_ADD, k0, 8'd0);
        send_op(ohs_pkg::KIND_ADD, {3'd2, 32'hA5A5_5A5A, 32'h1234_5678, 32'h8000_0001}, 8'd0);
        send_op(ohs_pkg::KIND_CONTAINS, k0, 8'd0);
        send_op(ohs_pkg::KIND_CONTAINS, {3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                8'd0);
        send_op(ohs_pkg::KIND_ADD, {3'd0, 32'd5, 32'd0, 32'd0}, 8'd0);
        send_op(ohs_pkg::KIND_CONTAINS, {3'd0, 32'd5, 32'd0, 32'd0}, 8'd0);
        send_op(ohs_pkg::KIND_REMOVE, {3'd0, 32'd5, 32'd0, 32'd0}, 8'd0);
        send_op(ohs_pkg::KIND_READ, k1, 8'd2);
        send_op(ohs_pkg::KIND_READ, k1, 8'd3);
        send_op(ohs_pkg::KIND_READ, k1, 8'd255);
        send_op(ohs_pkg::KIND_REMOVE, k0, 8'd0);
        send_op(ohs_pkg::KIND_READ, k1, 8'd0);
        send_op(ohs_pkg::KIND_REMOVE, k0, 8'd0);
        send_op(KIND_SPARE5, k1, 8'd0);
        send_op(KIND_SPARE6, k1, 8'd0);
        send_op(KIND_SPARE7, k1, 8'd0);
        send_op(ohs_pkg::KIND_CLEAR, k1, 8'd0);
        send_op(ohs_pkg::KIND_READ, k1, 8'd0);
        send_op(ohs_pkg::KIND_CONTAINS, k1, 8'd0);

        // Random phases with swapped idling, the last one with a receiver hold-off
        for (int p = 0; p < 3; p++) begin
            snd_idle_pct = (p == 0) ? 10 : (p == 1) ? 81 : 0;
            rcv_idle_pct = (p == 0) ? 81 : (p == 1) ? 10 : 0;
            if (p == 2) begin
                hold_cycles = 300;
                fill_and_drain();
            end
            for (int i = 0; i < 140; i++) random_op();
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        // Drain, then let the block settle
        wait_cycles = 0;
        while (sb.owed_results.size() != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (600) @(posedge i_clk);

        $display("checked %0d results: add %0d remove %0d contains %0d read %0d clear %0d",
                 sb.checked, sb.per_kind[ohs_pkg::KIND_ADD], sb.per_kind[ohs_pkg::KIND_REMOVE],
                 sb.per_kind[ohs_pkg::KIND_CONTAINS], sb.per_kind[ohs_pkg::KIND_READ],
                 sb.per_kind[ohs_pkg::KIND_CLEAR]);
        $display("covered a full set, adds past capacity, type-zero keys and spare kinds");
        if (sb.errors == 0 && sb.owed_results.size() == 0) begin
            $display("ordered_hash_set_engine_unit_tb: clean");
        end else begin
            $display("ordered_hash_set_engine_unit_tb: errors");
        end
        $finish;
    end

endmodule

FILE: ordered_hash_set_engine_unit.f
+incdir+rtl/core
rtl/core/ohs_pkg.sv
rtl/core/ohs_hash.sv
rtl/core/ohs_store.sv
rtl/core/ohs_ctrl.sv
rtl/core/ordered_hash_set_engine_unit.sv
test/ordered_hash_set_engine_unit_tb.sv
